// ===== rtl/core/lcpd_pkg.sv =====
// lcpd_pkg: shared constants, event codes and button debounce states
// for the led chase pwm driver; no dependencies.

package lcpd_pkg;

   localparam int LED_COUNT   = 8;
   localparam int PWM_BITS    = 5;
   localparam int TABLE_DEPTH = 8;
   localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);
   localparam int MASK_W      = 8;
   localparam int SPEED_W     = 8;
   localparam int ROTATE_W    = SPEED_W + 1;
   localparam int DEBOUNCE_W  = 8;
   localparam int PHASE_W     = TABLE_IDX_W;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(40);

   // brightness per table position, brightest first
   localparam logic [PWM_BITS-1:0] BRIGHT_TABLE [TABLE_DEPTH] = '{
      PWM_BITS'(31), PWM_BITS'(20), PWM_BITS'(11), PWM_BITS'(7),
      PWM_BITS'(4),  PWM_BITS'(2),  PWM_BITS'(1),  PWM_BITS'(0)
   };

   typedef enum logic [1:0] {
      OP_PWM_TICK = 2'd0,
      OP_MS_TICK  = 2'd1,
      OP_SPEED    = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      BTN_WAIT_PRESS   = 2'd0,
      BTN_PRESS_DB     = 2'd1,
      BTN_WAIT_RELEASE = 2'd2,
      BTN_RELEASE_DB   = 2'd3
   } btn_state_type;

endpackage

// ===== rtl/core/led_chase_pwm_driver.sv =====
// led_chase_pwm_driver: eight-led pwm chaser with rotating brightness,
// speed divider and debounced direction button. Depends on lcpd_pkg.
//
// Usage:
//   req channel carries one event word per handshake: req_tuser is the event
//   kind (pwm tick, millisecond tick, speed update, or an unused code that
//   changes nothing), req_tdata carries the button level and new speed.
//   rsp channel returns exactly one word per event: the led drive mask,
//   direction and current pattern phase, taken after the event's update.
//   csr_wr_en/csr_wr_data load the debounce length in millisecond ticks;
//   write it only while no event is in flight.
// Timing:
//   an accepted word lands in the input register; once the result register
//   can advance, its state update is applied and the result register loaded,
//   and the result then shows on rsp until it is taken.
//   One word per cycle is sustained while rsp does not stall: the
//   whole update is a single pass of counter, compare and table logic.
// Reset (synchronous, active high) clears all counters, phase, direction,
// speed and leds, returns the button machine to waiting for a press and
// loads the debounce length 40. When rsp stalls, the result register holds
// and one more word is taken into the input register before req_tready drops.

module led_chase_pwm_driver
   import lcpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] button_level, [8:1] speed_value, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] led_mask, [8] reverse, [11:9] phase_now
   input  logic                  csr_wr_en,
   input  logic [DEBOUNCE_W-1:0] csr_wr_data
);

   // input register
   logic               in_valid_ff, in_valid_in;
   op_type             in_op_ff;
   logic               in_level_ff;
   logic [SPEED_W-1:0] in_speed_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [MASK_W-1:0] out_mask_ff;
   logic              out_rev_ff;
   logic [PHASE_W-1:0] out_phase_ff;

   // block state
   logic [DEBOUNCE_W-1:0] db_ticks_ff;
   logic [PWM_BITS-1:0]   pwm_count_ff, pwm_count_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic                  dir_ff, dir_in;
   logic [SPEED_W-1:0]    speed_ff, speed_in;
   logic [ROTATE_W-1:0]   rotate_ff, rotate_in;
   btn_state_type         btn_ff, btn_in;
   logic [DEBOUNCE_W-1:0] db_count_ff, db_count_in;
   logic [MASK_W-1:0]     led_ff, led_in;

   logic advance;
   logic process;
   logic is_pwm, is_ms;

   logic [PWM_BITS:0]     pwm_next;
   logic [ROTATE_W-1:0]   rotate_next;
   logic [DEBOUNCE_W-1:0] db_limit;
   logic [DEBOUNCE_W-1:0] db_next;
   logic                  db_done;
   logic [MASK_W-1:0]     mask_calc;

   assign advance    = !out_valid_ff || rsp_tready;
   assign process    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign is_pwm     = process && (in_op_ff == OP_PWM_TICK);
   assign is_ms      = process && (in_op_ff == OP_MS_TICK);

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = process || (out_valid_ff && !rsp_tready);

   // pwm compare across leds
   assign pwm_next = {1'b0, pwm_count_ff} + (PWM_BITS+1)'(1);

   always_comb begin
      logic [TABLE_IDX_W-1:0] pos;
      mask_calc = '0;
      for (int i = 0; i < LED_COUNT; i++) begin
         pos = dir_ff ? phase_ff - TABLE_IDX_W'(i) : phase_ff + TABLE_IDX_W'(i);
         mask_calc[i] = (pwm_next <= {1'b0, BRIGHT_TABLE[pos]});
      end
   end

   assign rotate_next = rotate_ff + ROTATE_W'(1);
   assign db_limit    = (db_ticks_ff == '0) ? DEBOUNCE_W'(1) : db_ticks_ff;
   assign db_next     = db_count_ff + DEBOUNCE_W'(1);
   assign db_done     = (db_next >= db_limit);

   always_comb begin
      pwm_count_in = pwm_count_ff;
      led_in       = led_ff;
      phase_in     = phase_ff;
      rotate_in    = rotate_ff;
      speed_in     = speed_ff;
      if (is_pwm) begin
         pwm_count_in = pwm_next[PWM_BITS-1:0];
         led_in       = mask_calc;
      end
      if (is_ms) begin
         if (rotate_next > {1'b0, speed_ff}) begin
            phase_in  = phase_ff + PHASE_W'(1);
            rotate_in = '0;
         end else begin
            rotate_in = rotate_next;
         end
      end
      if (process && (in_op_ff == OP_SPEED)) begin
         speed_in = in_speed_ff;
      end
   end

   // button machine: next state
   always_comb begin
      btn_in = btn_ff;
      if (is_ms) begin
         unique case (btn_ff)
            BTN_WAIT_PRESS: begin
               if (!in_level_ff) btn_in = BTN_PRESS_DB;
            end
            BTN_PRESS_DB: begin
               if (db_done) btn_in = in_level_ff ? BTN_WAIT_PRESS : BTN_WAIT_RELEASE;
            end
            BTN_WAIT_RELEASE: begin
               if (in_level_ff) btn_in = BTN_RELEASE_DB;
            end
            BTN_RELEASE_DB: begin
               if (db_done) btn_in = in_level_ff ? BTN_WAIT_PRESS : BTN_WAIT_RELEASE;
            end
            default: btn_in = BTN_WAIT_PRESS;
         endcase
      end
   end

   // button machine: count and direction
   always_comb begin
      db_count_in = db_count_ff;
      dir_in      = dir_ff;
      if (is_ms) begin
         unique case (btn_ff)
            BTN_WAIT_PRESS: begin
               if (!in_level_ff) db_count_in = '0;
            end
            BTN_PRESS_DB: begin
               db_count_in = db_next;
               if (db_done && !in_level_ff) dir_in = !dir_ff;
            end
            BTN_WAIT_RELEASE: begin
               if (in_level_ff) db_count_in = '0;
            end
            BTN_RELEASE_DB: begin
               db_count_in = db_next;
            end
            default: db_count_in = db_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         db_ticks_ff  <= DEBOUNCE_RESET;
         pwm_count_ff <= '0;
         phase_ff     <= '0;
         dir_ff       <= 1'b0;
         speed_ff     <= '0;
         rotate_ff    <= '0;
         btn_ff       <= BTN_WAIT_PRESS;
         db_count_ff  <= '0;
         led_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) db_ticks_ff <= csr_wr_data;
         pwm_count_ff <= pwm_count_in;
         phase_ff     <= phase_in;
         dir_ff       <= dir_in;
         speed_ff     <= speed_in;
         rotate_ff    <= rotate_in;
         btn_ff       <= btn_in;
         db_count_ff  <= db_count_in;
         led_ff       <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff    <= op_type'(req_tuser);
         in_level_ff <= req_tdata[0];
         in_speed_ff <= req_tdata[8:1];
      end
      if (process) begin
         out_mask_ff  <= led_in;
         out_rev_ff   <= dir_in;
         out_phase_ff <= phase_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_phase_ff, out_rev_ff, out_mask_ff};

   // direction only flips on a processed millisecond tick
   a_dir_on_ms: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (dir_ff != $past(dir_ff))) |->
         $past(in_valid_ff && advance && (in_op_ff == OP_MS_TICK)))
      else $error("direction changed outside a millisecond tick");

   // rotate counter is cleared once it passes the speed
   a_rotate_bound: assert property (@(posedge clock) disable iff (reset)
      rotate_ff <= ROTATE_W'(256))
      else $error("rotate counter out of range");

   // a held input word is not lost or altered while the result side stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=>
         (in_valid_ff && $stable(in_op_ff) && $stable(in_level_ff) && $stable(in_speed_ff)))
      else $error("input word dropped during stall");

   // phase only moves on a processed millisecond tick
   a_phase_on_ms: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (phase_ff != $past(phase_ff))) |->
         $past(in_valid_ff && advance && (in_op_ff == OP_MS_TICK)))
      else $error("phase changed outside a millisecond tick");

endmodule
